FILE: rtl/agbd_pkg.sv
// Anchor-grid box decoder: shared types, register indexes and the sigmoid
// table generator (evaluated at elaboration only).
// No dependencies.
package agbd_pkg;

  localparam int LogitW  = 16;
  localparam int StrideW = 7;
  localparam int AnchorW = 10;
  localparam int SigW    = 16;
  localparam int LabelW  = 7;
  localparam int CountW  = 8;
  localparam int PosW    = 20;
  localparam int SizeW   = 19;
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 16;
  localparam int NumAnchorRegs = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_THRESH = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_STRIDE = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_A0_W   = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_A0_H   = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_A1_W   = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_A1_H   = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_A2_W   = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_A2_H   = 4'd7;

  localparam logic [63:0] ExpM1Q32 = 64'd1580030169;

  // which stored logit feeds the sigmoid lookup
  typedef enum logic [2:0] {
    SEL_X   = 3'd0,
    SEL_Y   = 3'd1,
    SEL_W   = 3'd2,
    SEL_H   = 3'd3,
    SEL_OBJ = 3'd4,
    SEL_CLS = 3'd5
  } sel_e;

  typedef struct packed {
    logic acc_en;
    sel_e sel;
    logic cap_po;
    logic cap_pc;
    logic cap_sx;
    logic cap_sy;
    logic cap_sw;
    logic cap_sh;
    logic do_conf;
    logic do_m1;
    logic do_m2;
    logic do_m3;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cell_go;   // last item of a cell with at least one class logit
    logic pass;      // both scores reach the threshold
    logic out_free;  // output register can take a new item
  } status_t;

  // restoring long division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg_q32(input logic [63:0] a16);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] e;
    logic signed [63:0] sum;
    n    = a16 >> 16;
    f    = a16 & 64'hFFFF;
    term = 64'd1 << 32;
    sum  = 64'sd1 <<< 32;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64(term * f, 64'd65536 * 64'(k));
      if ((k % 2) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    e = $unsigned(sum);
    for (int i = 0; i < 20; i++) begin
      if (64'(i) < n) e = (e * ExpM1Q32 + (64'd1 << 31)) >> 32;
    end
    return e;
  endfunction

  // table entry k of a depth-entry sigmoid table over [-16,16)
  function automatic logic [SigW-1:0] sig_entry(input int k, input int depth);
    logic signed [63:0] x;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;
    logic [63:0] r;
    x   = -(64'sd1 <<< 20) + $signed(udiv64((64'(2 * k + 1)) << 20, 64'(depth)));
    a   = (x < 0) ? $unsigned(-x) : $unsigned(x);
    e   = exp_neg_q32(a);
    den = (64'd1 << 32) + e;
    s   = udiv64(e * 64'd65536 + (den >> 1), den);
    r   = 64'd65536 - s;
    if (x < 0) return s[SigW-1:0];
    return (r > 64'd65535) ? 16'hFFFF : r[SigW-1:0];
  endfunction

endpackage

FILE: rtl/agbd_ctrl.sv
// Anchor-grid box decoder: sequencer for input acceptance and the per-cell tail
// (sigmoid lookups, threshold test, multiply steps, result hand-off). Uses agbd_pkg.
module agbd_ctrl import agbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    ST_ACC  = 11'b000_0000_0001,
    ST_LOBJ = 11'b000_0000_0010,
    ST_LCLS = 11'b000_0000_0100,
    ST_LX   = 11'b000_0000_1000,
    ST_LY   = 11'b000_0001_0000,
    ST_LW   = 11'b000_0010_0000,
    ST_LH   = 11'b000_0100_0000,
    ST_M1   = 11'b000_1000_0000,
    ST_M2   = 11'b001_0000_0000,
    ST_M3   = 11'b010_0000_0000,
    ST_FIN  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = SEL_OBJ;
    case (state_q)
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (status_i.cell_go) state_d = ST_LOBJ;
      end
      ST_LOBJ: begin
        cmd_o.sel = SEL_OBJ;
        state_d   = ST_LCLS;
      end
      ST_LCLS: begin
        cmd_o.sel    = SEL_CLS;
        cmd_o.cap_po = 1'b1;
        state_d      = ST_LX;
      end
      ST_LX: begin
        cmd_o.sel    = SEL_X;
        cmd_o.cap_pc = 1'b1;
        state_d      = ST_LY;
      end
      ST_LY: begin
        cmd_o.sel     = SEL_Y;
        cmd_o.cap_sx  = 1'b1;
        cmd_o.do_conf = 1'b1;
        state_d       = ST_LW;
      end
      ST_LW: begin
        cmd_o.sel    = SEL_W;
        cmd_o.cap_sy = 1'b1;
        state_d      = status_i.pass ? ST_LH : ST_ACC;
      end
      ST_LH: begin
        cmd_o.sel    = SEL_H;
        cmd_o.cap_sw = 1'b1;
        state_d      = ST_M1;
      end
      ST_M1: begin
        cmd_o.cap_sh = 1'b1;
        cmd_o.do_m1  = 1'b1;
        state_d      = ST_M2;
      end
      ST_M2: begin
        cmd_o.do_m2 = 1'b1;
        state_d     = ST_M3;
      end
      ST_M3: begin
        cmd_o.do_m3 = 1'b1;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("controller state not one-hot");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("result loaded over a waiting item");

endmodule

FILE: rtl/agbd_dpath.sv
// Anchor-grid box decoder datapath: logit capture, running argmax, shared
// sigmoid table, box arithmetic and the output register. Uses agbd_pkg.
module agbd_dpath import agbd_pkg::*; #(
  parameter int MAX_CLASSES         = 80,
  parameter int ANCHOR_SLOTS        = 3,
  parameter int SIGMOID_TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                in_valid_i,
  input  logic signed [15:0]  logit_i,
  input  logic                cell_last_i,
  input  logic [7:0]          grid_col_i,
  input  logic [7:0]          grid_row_i,
  input  logic [1:0]          anchor_sel_i,
  input  logic [SigW-1:0]     thresh_i,
  input  logic [StrideW-1:0]  stride_i,
  input  logic [AnchorW-1:0]  anc_w_i [NumAnchorRegs],
  input  logic [AnchorW-1:0]  anc_h_i [NumAnchorRegs],
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [PosW-1:0] box_left_o,
  output logic signed [PosW-1:0] box_top_o,
  output logic [SizeW-1:0]    box_width_o,
  output logic [SizeW-1:0]    box_height_o,
  output logic [LabelW-1:0]   class_label_o,
  output logic [SigW-1:0]     confidence_o
);

  localparam int IdxW = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int DepW = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int ProdW = 13 + DepW;

  // sigmoid table, built at elaboration
  logic [SigW-1:0] sig_rom [SIGMOID_TABLE_DEPTH];
  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [SigW-1:0] SigVal = sig_entry(g, SIGMOID_TABLE_DEPTH);
    assign sig_rom[g] = SigVal;
  end

  logic                     accept;
  logic [CountW-1:0]        count_q, count_d;
  logic [CountW-1:0]        cls_k;
  logic signed [LogitW-1:0] box_q [4];
  logic signed [LogitW-1:0] obj_q, best_q;
  logic [LabelW-1:0]        best_idx_q, best_idx_d, label_q;
  logic                     cls_upd;
  logic [7:0]               col_q, row_q;
  logic [1:0]               asel_q, asel_eff;

  assign accept = in_valid_i & cmd_i.acc_en;
  assign cls_k  = count_q - CountW'(5);
  assign cls_upd = (count_q >= CountW'(5)) && (cls_k < CountW'(MAX_CLASSES)) && !cls_k[7]
                   && ((cls_k == '0) || (logit_i > best_q));
  assign best_idx_d = cls_upd ? cls_k[LabelW-1:0] : best_idx_q;
  assign count_d = (count_q == {CountW{1'b1}}) ? count_q : count_q + CountW'(1);

  assign status_o.cell_go = accept && cell_last_i && (count_q >= CountW'(5));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      best_idx_q <= '0;
    end else if (accept) begin
      count_q    <= cell_last_i ? '0 : count_d;
      best_idx_q <= cell_last_i ? '0 : best_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (count_q < CountW'(4)) box_q[count_q[1:0]] <= logit_i;
      if (count_q == CountW'(4)) obj_q <= logit_i;
      if (cls_upd) best_q <= logit_i;
      if (cell_last_i) begin
        label_q <= best_idx_d;
        col_q   <= grid_col_i;
        row_q   <= grid_row_i;
        asel_q  <= anchor_sel_i;
      end
    end
  end

  // shared sigmoid lookup, registered read
  logic signed [LogitW-1:0] lk_logit;
  logic [12:0]              lk_off;
  logic [ProdW-1:0]         lk_prod;
  logic [SigW-1:0]          sig_q;

  always_comb begin
    case (cmd_i.sel)
      SEL_X:   lk_logit = box_q[0];
      SEL_Y:   lk_logit = box_q[1];
      SEL_W:   lk_logit = box_q[2];
      SEL_H:   lk_logit = box_q[3];
      SEL_OBJ: lk_logit = obj_q;
      SEL_CLS: lk_logit = best_q;
      default: lk_logit = obj_q;
    endcase
    if (lk_logit < -16'sd4096) lk_off = 13'd0;
    else if (lk_logit > 16'sd4095) lk_off = 13'd8191;
    else lk_off = 13'(lk_logit + 16'sd4096);
    lk_prod = ProdW'(lk_off) * ProdW'(SIGMOID_TABLE_DEPTH);
  end

  always_ff @(posedge clk_i) begin
    sig_q <= sig_rom[lk_prod[13 +: IdxW]];
  end

  // scores and box math
  logic [SigW-1:0]   po_q, pc_q, sx_q, sy_q, sw_q, sh_q, conf_q;
  logic [31:0]       conf_prod;
  logic signed [25:0] tx, ty;
  logic signed [33:0] ax_q, ay_q;
  logic [31:0]       sww_q, shh_q;
  logic [41:0]       bwh_q, bhh_q;

  assign asel_eff  = (asel_q >= 2'(ANCHOR_SLOTS)) ? 2'(ANCHOR_SLOTS - 1) : asel_q;
  assign conf_prod = 32'(po_q) * 32'(pc_q) + 32'd32768;
  assign tx = $signed({9'd0, sx_q, 1'b0}) - 26'sd32768 + $signed({2'b00, col_q, 16'd0});
  assign ty = $signed({9'd0, sy_q, 1'b0}) - 26'sd32768 + $signed({2'b00, row_q, 16'd0});
  assign status_o.pass = (po_q >= thresh_i) && (conf_q >= thresh_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_po) po_q <= sig_q;
    if (cmd_i.cap_pc) pc_q <= sig_q;
    if (cmd_i.cap_sx) sx_q <= sig_q;
    if (cmd_i.cap_sy) sy_q <= sig_q;
    if (cmd_i.cap_sw) sw_q <= sig_q;
    if (cmd_i.cap_sh) sh_q <= sig_q;
    if (cmd_i.do_conf) conf_q <= conf_prod[31:16];
    if (cmd_i.do_m1) begin
      ax_q  <= 34'(tx) * $signed({27'd0, stride_i});
      ay_q  <= 34'(ty) * $signed({27'd0, stride_i});
      sww_q <= 32'(sw_q) * 32'(sw_q);
    end
    if (cmd_i.do_m2) begin
      shh_q <= 32'(sh_q) * 32'(sh_q);
      bwh_q <= 42'(sww_q) * 42'(anc_w_i[asel_eff]);
    end
    if (cmd_i.do_m3) bhh_q <= 42'(shh_q) * 42'(anc_h_i[asel_eff]);
  end

  // final rounding to Q.4 and saturation
  logic signed [50:0] lf, tf;
  logic signed [22:0] lq, tq;
  logic [44:0]        wf, hf;
  logic signed [PosW-1:0] left_d, top_d;

  assign lf = (51'(ax_q) <<< 16) - 51'($signed({1'b0, bwh_q, 1'b0})) + 51'sd134217728;
  assign tf = (51'(ay_q) <<< 16) - 51'($signed({1'b0, bhh_q, 1'b0})) + 51'sd134217728;
  assign lq = 23'(lf >>> 28);
  assign tq = 23'(tf >>> 28);
  assign wf = {1'b0, bwh_q, 2'b00} + 45'd134217728;
  assign hf = {1'b0, bhh_q, 2'b00} + 45'd134217728;

  always_comb begin
    if (lq > 23'sd524287) left_d = 20'sd524287;
    else if (lq < -23'sd524288) left_d = -20'sd524288;
    else left_d = PosW'(lq);
    if (tq > 23'sd524287) top_d = 20'sd524287;
    else if (tq < -23'sd524288) top_d = -20'sd524288;
    else top_d = PosW'(tq);
  end

  // output register
  logic out_valid_q;
  assign out_valid_o      = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      box_left_o    <= left_d;
      box_top_o     <= top_d;
      box_width_o   <= SizeW'(wf[44:28]);
      box_height_o  <= SizeW'(hf[44:28]);
      class_label_o <= label_q;
      confidence_o  <= conf_q;
    end
  end

  a_cnt_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cell_last_i) |=> (count_q == '0))
    else $error("element count did not restart after cell end");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("loaded result not presented");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_m1 || cmd_i.do_conf) |-> !accept)
    else $error("item accepted during cell tail");

endmodule

FILE: rtl/anchor_grid_box_decoder.sv
// Anchor-grid box decoder top level: configuration registers, controller
// and datapath. Uses agbd_pkg, agbd_ctrl, agbd_dpath.
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata logit,col,row; tuser anchor; tlast cell end
// m_axis    out  m_axis_tvalid/tready        tdata left,top,width,height,label,conf
// cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One logit is taken per cycle while a cell streams in. After the last item
// of a cell with class logits, s_axis_tready stays low for six lookups through the
// one sigmoid table, then three multiply steps; when the threshold rejects, it
// rises after the width lookup. A waiting result stalls only the final hand-off.
// Reset restores the register defaults and empties the output register.
module anchor_grid_box_decoder import agbd_pkg::*; #(
  parameter int MAX_CLASSES         = 80,
  parameter int ANCHOR_SLOTS        = 3,
  parameter int SIGMOID_TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // logit[15:0], grid_col, grid_row
  input  logic [1:0]          s_axis_tuser,  // anchor_sel
  input  logic                s_axis_tlast,  // cell_last
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [103:0]        m_axis_tdata,  // box_left, box_top, box_width, box_height,
                                             // class_label, confidence, pad
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i
);

  logic [SigW-1:0]    thresh_q;
  logic [StrideW-1:0] stride_q;
  logic [AnchorW-1:0] anc_w_q [NumAnchorRegs];
  logic [AnchorW-1:0] anc_h_q [NumAnchorRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= 16'd16384;
      stride_q   <= 7'd8;
      anc_w_q[0] <= 10'd10;
      anc_h_q[0] <= 10'd13;
      anc_w_q[1] <= 10'd16;
      anc_h_q[1] <= 10'd30;
      anc_w_q[2] <= 10'd33;
      anc_h_q[2] <= 10'd23;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_THRESH: thresh_q   <= cfg_data_i;
        REG_STRIDE: stride_q   <= cfg_data_i[StrideW-1:0];
        REG_A0_W:   anc_w_q[0] <= cfg_data_i[AnchorW-1:0];
        REG_A0_H:   anc_h_q[0] <= cfg_data_i[AnchorW-1:0];
        REG_A1_W:   anc_w_q[1] <= cfg_data_i[AnchorW-1:0];
        REG_A1_H:   anc_h_q[1] <= cfg_data_i[AnchorW-1:0];
        REG_A2_W:   anc_w_q[2] <= cfg_data_i[AnchorW-1:0];
        REG_A2_H:   anc_h_q[2] <= cfg_data_i[AnchorW-1:0];
        default: ;
      endcase
    end
  end

  cmd_t    cmd;
  status_t status;

  logic signed [PosW-1:0] box_left, box_top;
  logic [SizeW-1:0]       box_width, box_height;
  logic [LabelW-1:0]      class_label;
  logic [SigW-1:0]        confidence;

  assign s_axis_tready = cmd.acc_en;

  agbd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  agbd_dpath #(
    .MAX_CLASSES         (MAX_CLASSES),
    .ANCHOR_SLOTS        (ANCHOR_SLOTS),
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_valid_i    (s_axis_tvalid),
    .logit_i       ($signed(s_axis_tdata[15:0])),
    .cell_last_i   (s_axis_tlast),
    .grid_col_i    (s_axis_tdata[23:16]),
    .grid_row_i    (s_axis_tdata[31:24]),
    .anchor_sel_i  (s_axis_tuser),
    .thresh_i      (thresh_q),
    .stride_i      (stride_q),
    .anc_w_i       (anc_w_q),
    .anc_h_i       (anc_h_q),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .box_left_o    (box_left),
    .box_top_o     (box_top),
    .box_width_o   (box_width),
    .box_height_o  (box_height),
    .class_label_o (class_label),
    .confidence_o  (confidence)
  );

  assign m_axis_tdata = {3'b000, confidence, class_label, box_height, box_width,
                         box_top, box_left};

endmodule
